/* rtl/dual_bitmap_allocator_defines.svh */
// Assertion helpers used by the allocator datapath.
`ifndef DUAL_BITMAP_ALLOCATOR_DEFINES_SVH
`define DUAL_BITMAP_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, masked during reset.
`define DBA_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, masked during reset.
`define DBA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/dba_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package dba_pkg;

  localparam int IDX_W         = 12;
  localparam int INODE_TOTAL_W = 9;
  localparam int BLOCK_TOTAL_W = 13;
  localparam int FREE_W        = 13;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 13;
  localparam int IN_USER_W     = 2;
  localparam int IN_DATA_W     = 16;
  localparam int OUT_DATA_W    = 32;

  localparam logic [INODE_TOTAL_W-1:0] INODE_TOTAL_RST = 9'd256;
  localparam logic [BLOCK_TOTAL_W-1:0] BLOCK_TOTAL_RST = 13'd4096;

  localparam logic [CFG_IDX_W-1:0] CFG_INODE_TOTAL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_TOTAL = 1'b1;

  localparam logic CMD_ALLOC   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;
  localparam logic POOL_INODE  = 1'b0;
  localparam logic POOL_BLOCK  = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DIV,
    ST_REM,
    ST_RCHK,
    ST_COMMIT,
    ST_EMIT
  } dba_state_t;

  typedef struct packed {
    logic clear;
    logic take;
    logic scan;
    logic div;
    logic rem;
    logic rel_check;
    logic commit;
    logic emit;
  } dba_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic is_release;
    logic refuse;
    logic hit;
    logic miss;
    logic bit_set;
    logic out_free;
  } dba_stat_t;

endpackage

`default_nettype wire

/* rtl/dual_bitmap_allocator.sv */
// Allocate: the result waits on a scan of the bitmap memory, read one word per cycle.
// Release: divide, read, check, write back if the bit was set; a refused index skips ahead.
// One item at a time: no new beat is taken until the last item is through its steps;
//   the next beat is taken while the last result still waits.
// Reset: synchronous; a clearing pass then zeroes both maps one row per cycle,
//   no item taken meanwhile.
`timescale 1ns / 1ps
`default_nettype none

module dual_bitmap_allocator #(
  parameter int INODE_MAX = 256,
  parameter int BLOCK_MAX = 4096,
  parameter int MAP_WORD  = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [dba_pkg::IN_DATA_W-1:0]     s_axis_tdata,   // index[11:0], zero pad
  input  logic [dba_pkg::IN_USER_W-1:0]     s_axis_tuser,   // command[0], pool[1]
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [dba_pkg::OUT_DATA_W-1:0]    m_axis_tdata,   // granted_index[11:0], free_count[24:12]
  output logic                              m_axis_tuser,   // ok
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [dba_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dba_pkg::CFG_DATA_W-1:0]    cfg_data
);

  import dba_pkg::*;

  localparam int CAP_MAX = (INODE_MAX > BLOCK_MAX) ? INODE_MAX : BLOCK_MAX;
  localparam int SPAN_W  = $clog2(CAP_MAX + 3 * MAP_WORD + 1);
  localparam int TOT_W   = (SPAN_W > BLOCK_TOTAL_W) ? SPAN_W : BLOCK_TOTAL_W;

  logic [INODE_TOTAL_W-1:0] inode_total;
  logic [BLOCK_TOTAL_W-1:0] block_total;
  logic [TOT_W-1:0]         inode_eff;
  logic [TOT_W-1:0]         block_eff;

  dba_cmd_t  cmd;
  dba_stat_t stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      inode_total <= INODE_TOTAL_RST;
      block_total <= BLOCK_TOTAL_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_INODE_TOTAL: inode_total <= cfg_data[INODE_TOTAL_W-1:0];
        CFG_BLOCK_TOTAL: block_total <= cfg_data[BLOCK_TOTAL_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp each total to the pool capacity.
  assign inode_eff = (TOT_W'(inode_total) > TOT_W'(INODE_MAX)) ? TOT_W'(INODE_MAX)
                                                               : TOT_W'(inode_total);
  assign block_eff = (TOT_W'(block_total) > TOT_W'(BLOCK_MAX)) ? TOT_W'(BLOCK_MAX)
                                                               : TOT_W'(block_total);

  dba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  dba_datapath #(
    .INODE_MAX (INODE_MAX),
    .BLOCK_MAX (BLOCK_MAX),
    .MAP_WORD  (MAP_WORD),
    .TOT_W     (TOT_W)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .in_user     (s_axis_tuser),
    .in_data     (s_axis_tdata),
    .inode_total (inode_eff),
    .block_total (block_eff),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_user    (m_axis_tuser),
    .out_data    (m_axis_tdata)
  );

endmodule

`default_nettype wire

/* rtl/dba_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module dba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                           wdata,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

/* rtl/dba_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module dba_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  dba_pkg::dba_stat_t stat,
  output dba_pkg::dba_cmd_t  cmd
);

  import dba_pkg::*;

  dba_state_t state;
  dba_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (stat.clear_done) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_next = stat.is_release ? ST_DIV : ST_SCAN;
      end
      ST_SCAN: begin
        if (stat.hit) state_next = ST_COMMIT;
        else if (stat.miss) state_next = ST_EMIT;
      end
      ST_DIV: begin
        state_next = stat.refuse ? ST_EMIT : ST_REM;
      end
      ST_REM: begin
        state_next = ST_RCHK;
      end
      ST_RCHK: begin
        state_next = stat.bit_set ? ST_COMMIT : ST_EMIT;
      end
      ST_COMMIT: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat.out_free) state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_CLEAR:  cmd.clear = 1'b1;
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
      end
      ST_SCAN:   cmd.scan = 1'b1;
      ST_DIV:    cmd.div = 1'b1;
      ST_REM:    cmd.rem = 1'b1;
      ST_RCHK:   cmd.rel_check = 1'b1;
      ST_COMMIT: cmd.commit = 1'b1;
      ST_EMIT:   cmd.emit = stat.out_free;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/dba_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "dual_bitmap_allocator_defines.svh"

module dba_datapath #(
  parameter int INODE_MAX = 256,
  parameter int BLOCK_MAX = 4096,
  parameter int MAP_WORD  = 32,
  parameter int TOT_W     = 13
) (
  input  logic                               clk,
  input  logic                               rst,
  input  dba_pkg::dba_cmd_t                  cmd,
  output dba_pkg::dba_stat_t                 stat,
  input  logic [dba_pkg::IN_USER_W-1:0]      in_user,
  input  logic [dba_pkg::IN_DATA_W-1:0]      in_data,
  input  logic [TOT_W-1:0]                   inode_total,
  input  logic [TOT_W-1:0]                   block_total,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_user,
  output logic [dba_pkg::OUT_DATA_W-1:0]     out_data
);

  import dba_pkg::*;

  localparam int INODE_ROWS = (INODE_MAX + MAP_WORD - 1) / MAP_WORD;
  localparam int BLOCK_ROWS = (BLOCK_MAX + MAP_WORD - 1) / MAP_WORD;
  localparam int ROWS_MAX   = (INODE_ROWS > BLOCK_ROWS) ? INODE_ROWS : BLOCK_ROWS;
  localparam int RW         = $clog2(ROWS_MAX + 1);
  localparam int BIT_W      = $clog2(MAP_WORD);
  localparam int INO_AW     = (INODE_ROWS > 1) ? $clog2(INODE_ROWS) : 1;
  localparam int BLK_AW     = (BLOCK_ROWS > 1) ? $clog2(BLOCK_ROWS) : 1;
  // Reciprocal scale: exact quotient for every 12-bit index.
  localparam int K          = IDX_W + BIT_W;
  localparam int PW         = K + ((RW > IDX_W + 1) ? RW : IDX_W + 1);
  localparam logic [PW-1:0]    RECIP  = PW'((2 ** K + MAP_WORD - 1) / MAP_WORD);
  localparam logic [TOT_W-1:0] WORD_T = TOT_W'(MAP_WORD);
  localparam logic [IDX_W-1:0] WORD_I = IDX_W'(MAP_WORD);
  localparam logic [MAP_WORD-1:0] ONE_W = MAP_WORD'(1);
  localparam int PAD_W      = OUT_DATA_W - FREE_W - IDX_W;

  // latched item
  logic             cmd_q;
  logic             pool_q;
  logic [IDX_W-1:0] idx_q;

  // scan pointers
  logic [RW-1:0]    rd_row;
  logic [TOT_W-1:0] rd_base;
  logic [RW-1:0]    chk_row;
  logic [TOT_W-1:0] chk_base;
  logic             chk_valid;

  logic [RW-1:0]       wr_row;
  logic [MAP_WORD-1:0] wr_word;
  logic [BIT_W-1:0]    bit_idx;
  logic [IDX_W-1:0]    granted;
  logic                ok_q;

  logic [TOT_W-1:0] inode_used;
  logic [TOT_W-1:0] block_used;

  logic              out_ok;
  logic [IDX_W-1:0]  out_granted;
  logic [FREE_W-1:0] out_free;

  logic [TOT_W-1:0]    total;
  logic [TOT_W-1:0]    used;
  logic [TOT_W-1:0]    free_cnt;
  logic [RW-1:0]       addr_row;
  logic                ino_we;
  logic                blk_we;
  logic [MAP_WORD-1:0] ram_wdata;
  logic [MAP_WORD-1:0] ino_q;
  logic [MAP_WORD-1:0] blk_q;
  logic [MAP_WORD-1:0] ram_q;
  logic [TOT_W-1:0]    lim;
  logic                in_range;
  logic [MAP_WORD-1:0] avail;
  logic                found;
  logic [BIT_W-1:0]    pos;
  logic [PW-1:0]       prod;
  logic [RW-1:0]       div_row;
  logic [IDX_W-1:0]    rem_full;

  assign total    = (pool_q == POOL_BLOCK) ? block_total : inode_total;
  assign used     = (pool_q == POOL_BLOCK) ? block_used : inode_used;
  assign free_cnt = (total > used) ? total - used : '0;

  assign addr_row  = (cmd.commit || cmd.rem) ? wr_row : rd_row;
  assign ino_we    = (cmd.clear && (rd_row < RW'(INODE_ROWS)))
                  || (cmd.commit && (pool_q == POOL_INODE));
  assign blk_we    = (cmd.clear && (rd_row < RW'(BLOCK_ROWS)))
                  || (cmd.commit && (pool_q == POOL_BLOCK));
  assign ram_wdata = cmd.clear ? '0 : wr_word;
  assign ram_q     = (pool_q == POOL_BLOCK) ? blk_q : ino_q;

  dba_ram #(
    .WIDTH (MAP_WORD),
    .DEPTH (INODE_ROWS)
  ) u_ino_map (
    .clk   (clk),
    .we    (ino_we),
    .addr  (INO_AW'(addr_row)),
    .wdata (ram_wdata),
    .rdata (ino_q)
  );

  dba_ram #(
    .WIDTH (MAP_WORD),
    .DEPTH (BLOCK_ROWS)
  ) u_blk_map (
    .clk   (clk),
    .we    (blk_we),
    .addr  (BLK_AW'(addr_row)),
    .wdata (ram_wdata),
    .rdata (blk_q)
  );

  // Bits at or above the pool total count as taken.
  assign in_range = chk_base < total;
  assign lim      = total - chk_base;

  always_comb begin
    for (int j = 0; j < MAP_WORD; j++) begin
      avail[j] = !ram_q[j] && (TOT_W'(j) < lim);
    end
  end

  always_comb begin
    found = 1'b0;
    pos   = '0;
    for (int j = MAP_WORD - 1; j >= 0; j--) begin
      if (avail[j]) begin
        found = 1'b1;
        pos   = BIT_W'(j);
      end
    end
  end

  assign prod     = PW'(idx_q) * RECIP;
  assign div_row  = prod[K +: RW];
  assign rem_full = idx_q - IDX_W'(wr_row) * WORD_I;

  always_comb begin
    stat            = '0;
    stat.clear_done = rd_row == RW'(ROWS_MAX - 1);
    stat.is_release = in_user[0] == CMD_RELEASE;
    stat.refuse     = (TOT_W'(idx_q) >= total)
                   || ((pool_q == POOL_BLOCK) && (idx_q == '0));
    stat.hit        = chk_valid && in_range && found;
    stat.miss       = chk_valid && !in_range;
    stat.bit_set    = ram_q[bit_idx];
    stat.out_free   = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_row     <= '0;
      chk_valid  <= 1'b0;
      ok_q       <= 1'b0;
      inode_used <= '0;
      block_used <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.take) begin
        rd_row    <= '0;
        chk_valid <= 1'b0;
        ok_q      <= 1'b0;
      end else if (cmd.clear || cmd.scan) begin
        rd_row    <= rd_row + RW'(1);
        chk_valid <= cmd.scan;
      end
      if (cmd.commit) begin
        ok_q <= 1'b1;
        if (pool_q == POOL_BLOCK) begin
          block_used <= (cmd_q == CMD_ALLOC) ? block_used + TOT_W'(1)
                                             : block_used - TOT_W'(1);
        end else begin
          inode_used <= (cmd_q == CMD_ALLOC) ? inode_used + TOT_W'(1)
                                             : inode_used - TOT_W'(1);
        end
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      cmd_q   <= in_user[0];
      pool_q  <= in_user[1];
      idx_q   <= in_data[IDX_W-1:0];
      rd_base <= '0;
      granted <= '0;
    end
    if (cmd.scan) begin
      rd_base  <= rd_base + WORD_T;
      chk_base <= rd_base;
      chk_row  <= rd_row;
      if (stat.hit) begin
        wr_row  <= chk_row;
        wr_word <= ram_q | (ONE_W << pos);
        granted <= IDX_W'(chk_base + TOT_W'(pos));
      end
    end
    if (cmd.div) begin
      wr_row <= div_row;
    end
    if (cmd.rem) begin
      bit_idx <= rem_full[BIT_W-1:0];
    end
    if (cmd.rel_check && stat.bit_set) begin
      wr_word <= ram_q & ~(ONE_W << bit_idx);
      granted <= idx_q;
    end
    if (cmd.emit) begin
      out_ok      <= ok_q;
      out_granted <= granted;
      out_free    <= FREE_W'(free_cnt);
    end
  end

  assign out_user = out_ok;
  assign out_data = {{PAD_W{1'b0}}, out_free, out_granted};

  `DBA_ASSERT_IMPL(a_ino_used_cap, clk, rst, 1'b1, inode_used <= TOT_W'(INODE_MAX), "record pool use above capacity")
  `DBA_ASSERT_IMPL(a_blk_used_cap, clk, rst, 1'b1, block_used <= TOT_W'(BLOCK_MAX), "block pool use above capacity")
  `DBA_ASSERT_NEXT(a_commit_ok, clk, rst, cmd.commit, ok_q, "committed beat not marked ok")
  `DBA_ASSERT_NEXT(a_used_hold, clk, rst, !cmd.commit, $stable(inode_used) && $stable(block_used), "use count moved without a commit")

endmodule

`default_nettype wire

/* verif/tb_dual_bitmap_allocator.sv */
`timescale 1ns / 1ps

module tb_dual_bitmap_allocator;
  import dba_pkg::*;

  localparam int REC_CAP      = 256;
  localparam int BLK_CAP      = 4096;
  localparam int LIMIT_CYCLES = 1000000;
  localparam int N_SETTINGS   = 7;
  localparam int PHASE_ITEMS  = 150;

  typedef struct packed {
    logic             cmd;
    logic             pool;
    logic [IDX_W-1:0] idx;
  } alloc_req_t;

  typedef struct packed {
    logic              ok;
    logic [IDX_W-1:0]  granted;
    logic [FREE_W-1:0] free;
  } alloc_rsp_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;  // index[11:0], zero pad
  logic [IN_USER_W-1:0]  s_axis_tuser = '0;  // command[0], pool[1]
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;       // granted_index[11:0], free_count[24:12]
  logic                  m_axis_tuser;       // ok
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  dual_bitmap_allocator uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow of both bitmaps and the total registers; taken[0] is the record pool.
  bit                      taken [2][BLK_CAP];
  int                      used_cnt [2];
  logic [INODE_TOTAL_W-1:0] rec_total_reg = INODE_TOTAL_RST;
  logic [BLOCK_TOTAL_W-1:0] blk_total_reg = BLOCK_TOTAL_RST;

  alloc_req_t pending_reqs [$];
  alloc_rsp_t due_results [$];

  int  pushed_items = 0;
  int  done_items   = 0;
  int  fails        = 0;
  int  n_alloc_ok   = 0;
  int  n_release_ok = 0;
  int  n_refused    = 0;
  int  cycles       = 0;
  bit  drv_calm     = 1'b0;
  bit  mon_calm     = 1'b0;

  function automatic int pool_limit(bit p);
    if (p == POOL_BLOCK)
      return (blk_total_reg > BLK_CAP) ? BLK_CAP : int'(blk_total_reg);
    return (rec_total_reg > REC_CAP) ? REC_CAP : int'(rec_total_reg);
  endfunction

  // First-fit allocate or release on the shadow maps; returns the result beat.
  function automatic alloc_rsp_t apply_request(alloc_req_t r);
    alloc_rsp_t rsp;
    int         lim;
    int         p;
    int         i;
    bit         refuse;
    rsp = '0;
    p   = r.pool;
    lim = pool_limit(r.pool);
    if (r.cmd == CMD_ALLOC) begin
      for (i = 0; i < lim; i++) begin
        if (!taken[p][i]) begin
          taken[p][i] = 1'b1;
          used_cnt[p]++;
          rsp.ok      = 1'b1;
          rsp.granted = i[IDX_W-1:0];
          break;
        end
      end
    end else begin
      refuse = (r.idx >= lim) || (r.pool == POOL_BLOCK && r.idx == 0);
      if (!refuse && taken[p][r.idx]) begin
        taken[p][r.idx] = 1'b0;
        used_cnt[p]--;
        rsp.ok      = 1'b1;
        rsp.granted = r.idx;
      end
    end
    rsp.free = (lim > used_cnt[p]) ? FREE_W'(lim - used_cnt[p]) : '0;
    return rsp;
  endfunction

  // Driver: present queued requests, with a random gap between them.
  alloc_req_t cur_req = '0;
  int         send_gap = 0;

  always @(posedge clk) begin : drive
    alloc_req_t nxt;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      send_gap      <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        due_results.push_back(apply_request(cur_req));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap != 0) begin
          send_gap      <= send_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          nxt = pending_reqs.pop_front();
          cur_req       <= nxt;
          s_axis_tdata  <= {{(IN_DATA_W-IDX_W){1'b0}}, nxt.idx};
          s_axis_tuser  <= {nxt.pool, nxt.cmd};
          s_axis_tvalid <= 1'b1;
          send_gap      <= drv_calm ? 0 : $urandom_range(0, 18);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result beat against the oldest prediction, stall at random.
  int stall = 0;

  always @(posedge clk) begin : watch
    alloc_rsp_t want;
    int         stall_n;
    if (rst) begin
      m_axis_tready <= 1'b0;
      stall         <= 0;
    end else begin
      stall_n = stall;
      if (m_axis_tvalid && m_axis_tready) begin
        if (due_results.size() == 0) begin
          $error("result beat with no request outstanding: tdata %h ok %0b",
                 m_axis_tdata, m_axis_tuser);
          fails++;
        end else begin
          want = due_results.pop_front();
          if (m_axis_tuser !== want.ok) begin
            $error("ok: expected %0d, got %0d", want.ok, m_axis_tuser);
            fails++;
          end
          if (m_axis_tdata[11:0] !== want.granted) begin
            $error("granted_index: expected %0d, got %0d", want.granted, m_axis_tdata[11:0]);
            fails++;
          end
          if (m_axis_tdata[24:12] !== want.free) begin
            $error("free_count: expected %0d, got %0d", want.free, m_axis_tdata[24:12]);
            fails++;
          end
          if (!want.ok)
            n_refused++;
          else if (m_axis_tuser === 1'b1 && want.granted == m_axis_tdata[11:0])
            ;
          done_items++;
        end
        stall_n = mon_calm ? 0 : $urandom_range(0, 18);
      end else if (stall_n != 0) begin
        stall_n = stall_n - 1;
      end
      stall         <= stall_n;
      m_axis_tready <= (stall_n == 0);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d of %0d results seen",
               cycles, done_items, pushed_items);
      $display("** dual_bitmap_allocator: FAILED **");
      $finish;
    end
  end

  task automatic queue_req(input logic cmd, input logic pool, input int idx);
    alloc_req_t r;
    r.cmd  = cmd;
    r.pool = pool;
    r.idx  = idx[IDX_W-1:0];
    pending_reqs.push_back(r);
    pushed_items++;
    if (cmd == CMD_ALLOC)
      n_alloc_ok++;
    else
      n_release_ok++;
  endtask

  // Hold further stimulus until every result has come back.
  task automatic drain();
    while (done_items != pushed_items)
      @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] r, input int v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data  <= v[CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (r == CFG_INODE_TOTAL)
      rec_total_reg = v[INODE_TOTAL_W-1:0];
    else
      blk_total_reg = v[BLOCK_TOTAL_W-1:0];
  endtask

  function automatic int pick_taken(bit p);
    int cap;
    int start;
    int k;
    int j;
    cap   = (p == POOL_BLOCK) ? BLK_CAP : REC_CAP;
    start = $urandom_range(0, cap - 1);
    for (k = 0; k < cap; k++) begin
      j = (start + k) % cap;
      if (taken[p][j])
        return j;
    end
    return start;
  endfunction

  // Allocates, releases of mostly live entries, some at edges or random indices.
  task automatic push_random(input int n, input int alloc_pct);
    int   k;
    int   roll;
    int   lim;
    int   idx;
    logic pool;
    logic cmd;
    for (k = 0; k < n; k++) begin
      pool = $urandom_range(0, 1);
      cmd  = ($urandom_range(0, 99) < alloc_pct) ? CMD_ALLOC : CMD_RELEASE;
      idx  = $urandom_range(0, 4095);
      if (cmd == CMD_RELEASE) begin
        roll = $urandom_range(0, 9);
        lim  = pool_limit(pool);
        if (roll < 6)
          idx = pick_taken(pool);
        else if (roll < 8)
          idx = $urandom_range(0, 4095);
        else begin
          case ($urandom_range(0, 3))
            0:       idx = 0;
            1:       idx = lim - 1;
            2:       idx = lim;
            default: idx = 4095;
          endcase
        end
      end
      queue_req(cmd, pool, idx);
    end
  endtask

  initial begin : stimulus
    int rec_set [N_SETTINGS];
    int blk_set [N_SETTINGS];
    int s;
    int count;
    int n;
    int pct;
    rec_set = '{256, 16, 1, 511, 5, 0, 200};
    blk_set = '{4096, 40, 1, 8191, 3, 9, 2000};

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Reset totals: refusals on empty maps, first-fit grants, block zero.
    queue_req(CMD_RELEASE, POOL_INODE, 0);
    queue_req(CMD_RELEASE, POOL_BLOCK, 0);
    queue_req(CMD_RELEASE, POOL_INODE, 256);
    queue_req(CMD_RELEASE, POOL_BLOCK, 4095);
    queue_req(CMD_ALLOC,   POOL_INODE, 4095);
    queue_req(CMD_ALLOC,   POOL_INODE, 0);
    queue_req(CMD_ALLOC,   POOL_BLOCK, 4095);
    queue_req(CMD_ALLOC,   POOL_BLOCK, 0);
    queue_req(CMD_RELEASE, POOL_BLOCK, 0);
    queue_req(CMD_RELEASE, POOL_BLOCK, 1);
    queue_req(CMD_RELEASE, POOL_INODE, 0);
    queue_req(CMD_RELEASE, POOL_INODE, 0);
    queue_req(CMD_RELEASE, POOL_INODE, 4095);
    drain();

    // Tiny pools: fill them, then release at the total.
    write_reg(CFG_INODE_TOTAL, 2);
    write_reg(CFG_BLOCK_TOTAL, 2);
    queue_req(CMD_ALLOC,   POOL_INODE, 0);
    queue_req(CMD_ALLOC,   POOL_INODE, 0);
    queue_req(CMD_ALLOC,   POOL_BLOCK, 0);
    queue_req(CMD_ALLOC,   POOL_BLOCK, 0);
    queue_req(CMD_RELEASE, POOL_BLOCK, 2);
    drain();

    // Total below use and an empty block pool.
    write_reg(CFG_INODE_TOTAL, 1);
    write_reg(CFG_BLOCK_TOTAL, 0);
    queue_req(CMD_ALLOC,   POOL_INODE, 0);
    queue_req(CMD_RELEASE, POOL_INODE, 1);
    queue_req(CMD_ALLOC,   POOL_BLOCK, 0);
    drain();

    // Totals above capacity act as the capacity.
    write_reg(CFG_INODE_TOTAL, 511);
    write_reg(CFG_BLOCK_TOTAL, 8191);
    queue_req(CMD_RELEASE, POOL_INODE, 1);
    queue_req(CMD_ALLOC,   POOL_INODE, 0);
    queue_req(CMD_RELEASE, POOL_BLOCK, 1);
    drain();

    for (s = 0; s < N_SETTINGS; s++) begin
      write_reg(CFG_INODE_TOTAL, rec_set[s]);
      write_reg(CFG_BLOCK_TOTAL, blk_set[s]);
      pct   = $urandom_range(40, 70);
      count = 0;
      while (count < PHASE_ITEMS) begin
        n        = $urandom_range(1, 40);
        drv_calm = ($urandom_range(0, 3) == 0);
        mon_calm = ($urandom_range(0, 3) == 0);
        push_random(n, pct);
        drain();
        count += n;
      end
    end

    repeat (150) @(posedge clk);
    if (due_results.size() != 0) begin
      $error("%0d predicted results never arrived", due_results.size());
      fails++;
    end
    $display("covered %0d requests (%0d allocate, %0d release) over %0d total settings,",
             pushed_items, n_alloc_ok, n_release_ok, N_SETTINGS + 4);
    $display("%0d of them refused or pool full; %0d field mismatches", n_refused, fails);
    if (fails == 0)
      $display("** dual_bitmap_allocator: PASSED **");
    else
      $display("** dual_bitmap_allocator: FAILED **");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/dba_pkg.sv
rtl/dba_ram.sv
rtl/dba_ctrl.sv
rtl/dba_datapath.sv
rtl/dual_bitmap_allocator.sv
verif/tb_dual_bitmap_allocator.sv
